// File: rtl/aws_pkg.sv
`default_nettype none
package aws_pkg;

  // default grid size
  localparam int GRID_X_DEF = 128;
  localparam int GRID_Z_DEF = 128;

  // register reset values
  localparam logic [31:0] TOS_RESET  = 32'd429497;
  localparam logic        REFL_RESET = 1'b1;
  localparam logic        ABS_RESET  = 1'b1;

  // register indexes
  localparam logic [1:0] CFG_TOS  = 2'd0;
  localparam logic [1:0] CFG_REFL = 2'd1;
  localparam logic [1:0] CFG_ABS  = 2'd2;

  // operation codes
  localparam logic [2:0] OP_WR_VEL = 3'd0;
  localparam logic [2:0] OP_WR_CUR = 3'd1;
  localparam logic [2:0] OP_WR_PRV = 3'd2;
  localparam logic [2:0] OP_STEP   = 3'd3;
  localparam logic [2:0] OP_RD_CUR = 3'd4;

  // acknowledge codes
  localparam logic [1:0] ACK_WRITE = 2'd0;
  localparam logic [1:0] ACK_STEP  = 2'd1;
  localparam logic [1:0] ACK_READ  = 2'd2;

  // product magnitude limit, 2^40
  localparam logic [43:0] PROD_LIM = 44'h100_0000_0000;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_IN_RD,
    ST_VR,
    ST_C2,
    ST_MQ,
    ST_IN_WR,
    ST_ED_RD,
    ST_ED_MQ2,
    ST_ED_FIN,
    ST_ED_DIV,
    ST_ED_WR,
    ST_CP
  } state_t;

endpackage
`default_nettype wire

// File: rtl/acoustic_wave_stencil_step.sv
`default_nettype none
// 2-D acoustic wave engine with four grid stores (velocity, previous, current
// and next pressure) and one-way absorbing edges.
// Input: an item is taken when start is high and busy is low (op, pos_x, pos_z,
// value). Each item gives exactly one result beat: done is high for one cycle
// with read_value and ack_kind; the receiver cannot stall and needs no ready.
// Configuration: cfg_we/cfg_index/cfg_data write a register at once; the user
// must write only while idle, which the block itself does not enforce.
// Reset: after rst all stores are swept to zero, one cell per cycle, with busy
// high; then the block is idle. A write (or unknown op) is answered in the next
// cycle and the block takes a new item at once. A read fetches its cell in
// ST_READ and is answered after it. A step walks the interior cells, then,
// when absorb is set, the edge cells through a bit-serial divider, then shifts
// the stores; all products go through one shared 32x32 multiplier and each
// store has one read and one write port, so one store's operands are fetched
// one per cycle. Busy stays high during the step.
module acoustic_wave_stencil_step #(
  parameter int GRID_X = aws_pkg::GRID_X_DEF,
  parameter int GRID_Z = aws_pkg::GRID_Z_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         op,
  input  wire logic [6:0]         pos_x,
  input  wire logic [6:0]         pos_z,
  input  wire logic signed [31:0] value,
  output logic                    done,
  output logic signed [31:0]      read_value,
  output logic [1:0]              ack_kind,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  import aws_pkg::*;

  localparam int XW    = $clog2(GRID_X);
  localparam int ZW    = $clog2(GRID_Z);
  localparam int CW    = (XW > ZW) ? XW : ZW;
  localparam int CELLS = GRID_X * GRID_Z;
  localparam int AW    = $clog2(CELLS);

  function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x,
                                               input logic [ZW-1:0] z);
    cell_addr = AW'(int'(x) * GRID_Z + int'(z));
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    if (v > 48'sh0000_7fff_ffff) sat32 = 32'sh7fff_ffff;
    else if (v < -48'sh0000_8000_0000) sat32 = 32'sh8000_0000;
    else sat32 = v[31:0];
  endfunction

  // configuration registers
  logic [31:0] tos;
  logic        refl;
  logic        absorb;

  always_ff @(posedge clk) begin
    if (rst) begin
      tos    <= TOS_RESET;
      refl   <= REFL_RESET;
      absorb <= ABS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TOS:  tos <= cfg_data;
        CFG_REFL: refl <= cfg_data[0];
        CFG_ABS:  absorb <= cfg_data[0];
        default:  ;
      endcase
    end
  end

  // grid stores
  logic        [15:0] vel_mem [CELLS];
  logic signed [31:0] prv_mem [CELLS];
  logic signed [31:0] cur_mem [CELLS];
  logic signed [31:0] nxt_mem [CELLS];

  logic [AW-1:0]      vel_ra, prv_ra, cur_ra, nxt_ra;
  logic [AW-1:0]      vel_wa, prv_wa, cur_wa, nxt_wa;
  logic               vel_we, prv_we, cur_we, nxt_we;
  logic [15:0]        vel_wd;
  logic signed [31:0] prv_wd, cur_wd, nxt_wd;
  logic [15:0]        vel_q;
  logic signed [31:0] prv_q, cur_q, nxt_q;

  always_ff @(posedge clk) begin
    vel_q <= vel_mem[vel_ra];
    if (vel_we) vel_mem[vel_wa] <= vel_wd;
  end

  always_ff @(posedge clk) begin
    prv_q <= prv_mem[prv_ra];
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
  end

  always_ff @(posedge clk) begin
    cur_q <= cur_mem[cur_ra];
    if (cur_we) cur_mem[cur_wa] <= cur_wd;
  end

  always_ff @(posedge clk) begin
    nxt_q <= nxt_mem[nxt_ra];
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
  end

  // sequencer and datapath registers
  state_t state, state_next, mq_ret;
  logic [6:0]  ph, ph_next;
  logic [AW-1:0] cnt;
  logic [XW-1:0] cx;
  logic [ZW-1:0] cz;
  logic [1:0]    sw;
  logic [CW-1:0] ecnt;
  logic          edge_mode;
  logic          rd_in;

  logic signed [34:0] nsum;
  logic               nz;
  logic signed [31:0] ctr, prv;
  logic [15:0]        vv;
  logic [31:0]        vr;
  logic [63:0]        c2;
  logic signed [31:0] p1i, p1k, p1j, p2i, p2j, cj;
  logic signed [45:0] nacc;

  logic [42:0]        mq_m;
  logic               mq_neg;
  logic [63:0]        mq_b;
  logic [43:0]        mq_acc;
  logic               mq_ovf;
  logic signed [43:0] mq_res;

  logic [32:0] div_d;
  logic [33:0] div_rem;
  logic [63:0] div_q;
  logic        div_neg;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  always_ff @(posedge clk) begin
    mul_p <= 64'(mul_a) * 64'(mul_b);
  end

  // item decode
  logic          accept, in_grid;
  logic [AW-1:0] pos_addr;

  assign accept   = start && !busy;
  assign in_grid  = (int'(pos_x) < GRID_X) && (int'(pos_z) < GRID_Z);
  assign pos_addr = cell_addr(XW'(pos_x), ZW'(pos_z));

  // interior cell and neighbors
  logic [AW-1:0] c_addr, up_addr, dn_addr, lf_addr, rt_addr;
  logic          quiet, in_last, in_adv;

  assign c_addr  = cell_addr(cx, cz);
  assign up_addr = cell_addr(cx, cz - 1'b1);
  assign dn_addr = cell_addr(cx, cz + 1'b1);
  assign lf_addr = cell_addr(cx - 1'b1, cz);
  assign rt_addr = cell_addr(cx + 1'b1, cz);
  assign quiet   = (prv_q == 32'sd0) && !nz;
  assign in_last = (cx == XW'(GRID_X - 2)) && (cz == ZW'(GRID_Z - 2));
  assign in_adv  = (state == ST_IN_RD && ph == 7'd5 && quiet) || state == ST_IN_WR;

  // edge cell i with its inward neighbors k and j
  logic [AW-1:0] ai, ak, aj;
  logic [XW-1:0] ex;
  logic [ZW-1:0] ez;
  logic          ed_last_cell, ed_last;

  assign ex = XW'(ecnt);
  assign ez = ZW'(ecnt);

  always_comb begin
    case (sw)
      2'd0: begin
        ai = cell_addr(ex, ZW'(0));
        ak = cell_addr(ex, ZW'(1));
        aj = cell_addr(ex, ZW'(2));
      end
      2'd1: begin
        ai = cell_addr(ex, ZW'(GRID_Z - 1));
        ak = cell_addr(ex, ZW'(GRID_Z - 2));
        aj = cell_addr(ex, ZW'(GRID_Z - 3));
      end
      2'd2: begin
        ai = cell_addr(XW'(0), ez);
        ak = cell_addr(XW'(1), ez);
        aj = cell_addr(XW'(2), ez);
      end
      default: begin
        ai = cell_addr(XW'(GRID_X - 1), ez);
        ak = cell_addr(XW'(GRID_X - 2), ez);
        aj = cell_addr(XW'(GRID_X - 3), ez);
      end
    endcase
  end

  assign ed_last_cell = sw[1] ? (ecnt == CW'(GRID_Z - 1)) : (ecnt == CW'(GRID_X - 1));
  assign ed_last      = ed_last_cell && (sw == 2'd3);

  // arithmetic helpers
  logic signed [45:0] lap, ea1, ea2, in_sum, nacc0;
  logic signed [46:0] nd;
  logic [45:0]        nmag;
  logic [32:0]        dd;
  logic [43:0]        mq_r;
  logic [33:0]        rem_sh;
  logic               rem_ge;
  logic signed [31:0] ed_val;

  assign lap    = 46'(nsum) - (46'(ctr) <<< 2);
  assign ea1    = 46'(cj) - 46'(p2j) + 46'(p2i);
  assign ea2    = 46'(p1j) - (46'(p1k) <<< 1) + 46'(p1i);
  assign nacc0  = (46'(p1i) <<< 1) - 46'(p2i) - 46'(cj) + (46'(p1j) <<< 1) - 46'(p2j);
  assign in_sum = 46'(mq_res) + (46'(ctr) <<< 1) - 46'(prv);
  assign nd     = 47'(nacc) - (47'(mq_res) <<< 1);
  assign nmag   = nd[46] ? 46'(-nd) : 46'(nd);
  assign dd     = 33'h1_0000 + {1'b0, vr};
  assign mq_r   = (mq_ovf || mq_acc > PROD_LIM) ? PROD_LIM : mq_acc;
  assign rem_sh = {div_rem[32:0], div_q[63]};
  assign rem_ge = rem_sh >= {1'b0, div_d};

  always_comb begin
    if (!div_neg) ed_val = (div_q > 64'h7fff_ffff) ? 32'sh7fff_ffff : div_q[31:0];
    else ed_val = (div_q > 64'h8000_0000) ? 32'sh8000_0000 : -div_q[31:0];
  end

  // product unit operand load
  logic               mq_load;
  logic signed [45:0] mq_in;
  logic [63:0]        mq_bin;
  state_t             mq_ret_in;

  always_comb begin
    mq_load   = 1'b0;
    mq_in     = lap;
    mq_bin    = mul_p;
    mq_ret_in = ST_IN_WR;
    if (state == ST_C2 && ph == 7'd1) begin
      mq_load = 1'b1;
      if (edge_mode) begin
        mq_in     = ea1;
        mq_bin    = {16'd0, vr, 16'd0};
        mq_ret_in = ST_ED_MQ2;
      end
    end else if (state == ST_ED_MQ2) begin
      mq_load   = 1'b1;
      mq_in     = ea2;
      mq_bin    = c2;
      mq_ret_in = ST_ED_FIN;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      ph    <= 7'd0;
    end else begin
      state <= state_next;
      ph    <= ph_next;
    end
  end

  // next state, store ports and multiplier operands
  always_comb begin
    state_next = state;
    ph_next    = ph + 7'd1;
    vel_ra = c_addr;
    prv_ra = c_addr;
    cur_ra = c_addr;
    nxt_ra = aj;
    vel_we = 1'b0;
    prv_we = 1'b0;
    cur_we = 1'b0;
    nxt_we = 1'b0;
    vel_wa = cnt;
    prv_wa = cnt;
    cur_wa = cnt;
    nxt_wa = cnt;
    vel_wd = 16'd0;
    prv_wd = 32'sd0;
    cur_wd = 32'sd0;
    nxt_wd = 32'sd0;
    mul_a  = 32'd0;
    mul_b  = 32'd0;
    case (state)
      ST_CLEAR: begin
        vel_we = 1'b1;
        prv_we = 1'b1;
        cur_we = 1'b1;
        nxt_we = 1'b1;
        if (cnt == AW'(CELLS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        ph_next = 7'd0;
        cur_ra = pos_addr;
        vel_wa = pos_addr;
        prv_wa = pos_addr;
        cur_wa = pos_addr;
        vel_wd = value[15:0];
        prv_wd = value;
        cur_wd = value;
        if (accept) begin
          case (op)
            OP_WR_VEL: vel_we = in_grid;
            OP_WR_CUR: cur_we = in_grid;
            OP_WR_PRV: prv_we = in_grid;
            OP_STEP:   state_next = ST_IN_RD;
            OP_RD_CUR: state_next = ST_READ;
            default:   ;
          endcase
        end
      end
      ST_READ: state_next = ST_IDLE;
      ST_IN_RD: begin
        case (ph)
          7'd0:    cur_ra = up_addr;
          7'd1:    cur_ra = dn_addr;
          7'd2:    cur_ra = lf_addr;
          7'd3:    cur_ra = rt_addr;
          default: cur_ra = c_addr;
        endcase
        if (ph == 7'd5) begin
          ph_next = 7'd0;
          if (!quiet) state_next = ST_VR;
          else if (in_last) state_next = absorb ? ST_ED_RD : ST_CP;
        end
      end
      ST_VR: begin
        mul_a = {16'd0, vv};
        mul_b = tos;
        if (ph == 7'd1) begin
          state_next = ST_C2;
          ph_next    = 7'd0;
        end
      end
      ST_C2: begin
        mul_a = vr;
        mul_b = vr;
        if (ph == 7'd1) begin
          state_next = ST_MQ;
          ph_next    = 7'd0;
        end
      end
      ST_MQ: begin
        case (ph)
          7'd0: begin
            mul_a = mq_m[31:0];
            mul_b = mq_b[31:0];
          end
          7'd1: begin
            mul_a = mq_m[31:0];
            mul_b = mq_b[63:32];
          end
          7'd2: begin
            mul_a = {21'd0, mq_m[42:32]};
            mul_b = mq_b[31:0];
          end
          7'd3: begin
            mul_a = {21'd0, mq_m[42:32]};
            mul_b = mq_b[63:32];
          end
          default: ;
        endcase
        if (ph == 7'd5) begin
          state_next = mq_ret;
          ph_next    = 7'd0;
        end
      end
      ST_IN_WR: begin
        nxt_we  = 1'b1;
        nxt_wa  = c_addr;
        nxt_wd  = sat32(48'(in_sum));
        ph_next = 7'd0;
        if (in_last) state_next = absorb ? ST_ED_RD : ST_CP;
        else state_next = ST_IN_RD;
      end
      ST_ED_RD: begin
        vel_ra = ai;
        prv_ra = (ph == 7'd0) ? ai : aj;
        case (ph)
          7'd0:    cur_ra = ai;
          7'd1:    cur_ra = ak;
          default: cur_ra = aj;
        endcase
        if (ph == 7'd3) begin
          state_next = ST_VR;
          ph_next    = 7'd0;
        end
      end
      ST_ED_MQ2: begin
        state_next = ST_MQ;
        ph_next    = 7'd0;
      end
      ST_ED_FIN: begin
        state_next = ST_ED_DIV;
        ph_next    = 7'd0;
      end
      ST_ED_DIV: begin
        if (ph == 7'd63) begin
          state_next = ST_ED_WR;
          ph_next    = 7'd0;
        end
      end
      ST_ED_WR: begin
        nxt_we     = 1'b1;
        nxt_wa     = ai;
        nxt_wd     = ed_val;
        ph_next    = 7'd0;
        state_next = ed_last ? ST_CP : ST_ED_RD;
      end
      ST_CP: begin
        cur_ra = cnt;
        nxt_ra = cnt;
        prv_wd = cur_q;
        cur_wd = nxt_q;
        if (ph[0]) begin
          prv_we  = 1'b1;
          cur_we  = 1'b1;
          ph_next = 7'd0;
          if (cnt == AW'(CELLS - 1)) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

  // control counters and result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_CLEAR: cnt <= (cnt == AW'(CELLS - 1)) ? '0 : cnt + 1'b1;
        ST_IDLE: begin
          cnt <= '0;
          if (accept && op != OP_STEP && op != OP_RD_CUR) done <= 1'b1;
        end
        ST_READ: done <= 1'b1;
        ST_CP: begin
          if (ph[0]) begin
            cnt <= (cnt == AW'(CELLS - 1)) ? '0 : cnt + 1'b1;
            if (cnt == AW'(CELLS - 1)) done <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      read_value <= 32'sd0;
      ack_kind   <= ACK_WRITE;
      rd_in      <= in_grid;
    end else if (state == ST_READ) begin
      read_value <= rd_in ? cur_q : 32'sd0;
      ack_kind   <= ACK_READ;
    end else if (state == ST_CP) begin
      read_value <= 32'sd0;
      ack_kind   <= ACK_STEP;
    end
  end

  // walk order over interior and edges
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      cx        <= XW'(1);
      cz        <= ZW'(1);
      nsum      <= '0;
      nz        <= 1'b0;
      edge_mode <= 1'b0;
      sw        <= refl ? 2'd1 : 2'd0;
      ecnt      <= '0;
    end else begin
      if (state == ST_ED_RD) edge_mode <= 1'b1;
      if (state == ST_IN_RD && ph >= 7'd1 && ph <= 7'd4) begin
        nsum <= nsum + 35'(cur_q);
        nz   <= nz | (cur_q != 32'sd0);
      end
      if (in_adv) begin
        nsum <= '0;
        nz   <= 1'b0;
        if (cz == ZW'(GRID_Z - 2)) begin
          cz <= ZW'(1);
          cx <= cx + 1'b1;
        end else begin
          cz <= cz + 1'b1;
        end
      end
      if (state == ST_ED_WR) begin
        if (ed_last_cell) begin
          sw   <= sw + 2'd1;
          ecnt <= '0;
        end else begin
          ecnt <= ecnt + 1'b1;
        end
      end
    end
  end

  // operand capture and arithmetic
  always_ff @(posedge clk) begin
    case (state)
      ST_IN_RD: begin
        if (ph == 7'd5) begin
          ctr <= cur_q;
          prv <= prv_q;
          vv  <= vel_q;
        end
      end
      ST_ED_RD: begin
        case (ph)
          7'd1: begin
            p1i <= cur_q;
            p2i <= prv_q;
          end
          7'd2: begin
            p1k <= cur_q;
            p2j <= prv_q;
          end
          7'd3: begin
            p1j <= cur_q;
            cj  <= nxt_q;
            vv  <= vel_q;
          end
          default: ;
        endcase
      end
      ST_VR: if (ph == 7'd1) vr <= 32'((mul_p + 64'h8000) >> 16);
      ST_C2: if (ph == 7'd1) begin
        c2   <= mul_p;
        nacc <= nacc0;
      end
      ST_ED_MQ2: nacc <= nacc + 46'(mq_res);
      ST_MQ: begin
        case (ph)
          7'd1: begin
            mq_acc <= 44'((mul_p + 64'h8000_0000) >> 32);
            mq_ovf <= 1'b0;
          end
          7'd2, 7'd3: begin
            if (mul_p > 64'(PROD_LIM)) mq_ovf <= 1'b1;
            else mq_acc <= mq_acc + mul_p[43:0];
          end
          7'd4: begin
            if (mul_p >= 64'd256) mq_ovf <= 1'b1;
            else mq_acc <= mq_acc + {mul_p[11:0], 32'd0};
          end
          7'd5: mq_res <= mq_neg ? -$signed(mq_r) : $signed(mq_r);
          default: ;
        endcase
      end
      ST_ED_FIN: begin
        div_neg <= nd[46];
        div_d   <= dd;
        div_rem <= '0;
        div_q   <= (64'(nmag) << 16) + 64'(dd >> 1);
      end
      ST_ED_DIV: begin
        div_rem <= rem_ge ? rem_sh - {1'b0, div_d} : rem_sh;
        div_q   <= {div_q[62:0], rem_ge};
      end
      default: ;
    endcase
    if (mq_load) begin
      mq_neg <= mq_in[45];
      mq_m   <= 43'(mq_in[45] ? -mq_in : mq_in);
      mq_b   <= mq_bin;
      mq_ret <= mq_ret_in;
    end
  end

  // checks
  a_step_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && op == OP_STEP) |=> busy)
    else $error("step item did not make the block busy");

  a_long_ack: assert property (@(posedge clk) disable iff (rst)
    (done && ack_kind != ACK_WRITE) |-> $past(busy))
    else $error("read or step beat without prior work");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ED_DIV) |-> (div_rem < {1'b0, div_d}))
    else $error("divider remainder out of range");

endmodule
`default_nettype wire

// File: dv/testbench.sv
module testbench;
  import aws_pkg::*;

  localparam int NX = GRID_X_DEF;
  localparam int NZ = GRID_Z_DEF;
  localparam int CELLS = NX * NZ;
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int EXP_DEPTH = 16;
  localparam logic [127:0] SAT_MAG = 128'h100_0000_0000;

  typedef struct packed {
    logic [2:0]  op;
    logic [6:0]  x;
    logic [6:0]  z;
    logic [31:0] val;
    bit          fixed;
    logic [31:0] rv;
    logic [1:0]  ack;
  } dir_row_t;

  typedef struct packed {
    logic [31:0] rv;
    logic [1:0]  ack;
  } ack_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [2:0] op = '0;
  logic [6:0] pos_x = '0;
  logic [6:0] pos_z = '0;
  logic signed [31:0] value = '0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic busy, done;
  logic signed [31:0] read_value;
  logic [1:0] ack_kind;

  int errors = 0;
  int cycles = 0;

  // expected beats, oldest at exp_rd
  ack_beat_t exp_fifo[EXP_DEPTH];
  int exp_wr = 0;
  int exp_rd = 0;

  // local copy of the grid stores and registers
  logic [15:0] vel_m[CELLS];
  logic signed [31:0] prv_m[CELLS];
  logic signed [31:0] cur_m[CELLS];
  logic signed [31:0] nxt_m[CELLS];
  logic [31:0] tos_m = TOS_RESET;
  logic refl_m = REFL_RESET;
  logic abs_m = ABS_RESET;

  acoustic_wave_stencil_step dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .pos_x(pos_x),
    .pos_z(pos_z), .value(value), .done(done), .read_value(read_value),
    .ack_kind(ack_kind), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // result beat check against oldest expectation
  always @(posedge clk) begin
    ack_beat_t want;
    if (!rst && done) begin
      if (exp_wr == exp_rd) begin
        report($sformatf("unexpected beat rv=%h ack=%0d", read_value, ack_kind));
      end else begin
        want = exp_fifo[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (read_value !== want.rv)
          report($sformatf("read_value %h, want %h", read_value, want.rv));
        if (ack_kind !== want.ack)
          report($sformatf("ack_kind %0d, want %0d", ack_kind, want.ack));
      end
    end
  end

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // round(a*b/2^32) half away from zero, clamped to 2^40
  function automatic longint mul_round(input longint a, input logic [63:0] b);
    logic [63:0] m;
    logic [127:0] pr;
    m = (a < 0) ? 64'(-a) : 64'(a);
    pr = {64'b0, m} * {64'b0, b};
    pr = (pr + 128'h8000_0000) >> 32;
    if (pr > SAT_MAG) pr = SAT_MAG;
    return (a < 0) ? -longint'(pr[63:0]) : longint'(pr[63:0]);
  endfunction

  function automatic logic [63:0] courant(input int i);
    logic [63:0] p;
    p = {48'b0, vel_m[i]} * {32'b0, tos_m};
    return (p + 64'h8000) >> 16;
  endfunction

  // one-way absorbing update of boundary cell i, k one and j two cells inward
  function automatic void rim_update(input int i, input int k, input int j);
    logic [63:0] vr, c2, d, mag, q;
    longint p1i, p1k, p1j, p2i, p2j, cj, n;
    vr = courant(i);
    c2 = vr * vr;
    p1i = cur_m[i]; p1k = cur_m[k]; p1j = cur_m[j];
    p2i = prv_m[i]; p2j = prv_m[j]; cj = nxt_m[j];
    n = 2 * p1i - p2i - cj + 2 * p1j - p2j;
    n += mul_round(cj - p2j + p2i, vr << 16);
    n -= 2 * mul_round(p1j - 2 * p1k + p1i, c2);
    d = 64'd65536 + vr;
    mag = (n < 0) ? 64'(-n) : 64'(n);
    q = ((mag << 16) + d / 2) / d;
    nxt_m[i] = 32'(sat32((n < 0) ? -longint'(q) : longint'(q)));
  endfunction

  function automatic void wave_step();
    int i;
    logic [63:0] vr;
    longint up, dn, lf, rt, ctr, prv, lap;
    // interior stencil, quiet cells keep their old next value
    for (int x = 1; x < NX - 1; x++) begin
      for (int z = 1; z < NZ - 1; z++) begin
        i = z + x * NZ;
        up = cur_m[i - 1]; dn = cur_m[i + 1];
        lf = cur_m[i - NZ]; rt = cur_m[i + NZ];
        ctr = cur_m[i]; prv = prv_m[i];
        if (prv != 0 || up != 0 || dn != 0 || lf != 0 || rt != 0) begin
          vr = courant(i);
          lap = -4 * ctr + up + dn + lf + rt;
          nxt_m[i] = 32'(sat32(mul_round(lap, vr * vr) + 2 * ctr - prv));
        end
      end
    end
    // boundary sweeps when absorbing: top (unless refl), bottom, left, right
    if (abs_m) begin
      if (!refl_m)
        for (int x = 0; x < NX; x++) rim_update(x * NZ, x * NZ + 1, x * NZ + 2);
      for (int x = 0; x < NX; x++)
        rim_update(x * NZ + NZ - 1, x * NZ + NZ - 2, x * NZ + NZ - 3);
      for (int z = 0; z < NZ; z++) rim_update(z, z + NZ, z + 2 * NZ);
      for (int z = 0; z < NZ; z++)
        rim_update(z + (NX - 1) * NZ, z + (NX - 2) * NZ, z + (NX - 3) * NZ);
    end
    // store shift
    for (int c = 0; c < CELLS; c++) begin
      prv_m[c] = cur_m[c];
      cur_m[c] = nxt_m[c];
    end
  endfunction

  function automatic ack_beat_t apply_item(input logic [2:0] o, input logic [6:0] x,
                                           input logic [6:0] z, input logic [31:0] v);
    ack_beat_t r;
    int i;
    i = int'(z) + int'(x) * NZ;
    r.rv = '0;
    r.ack = ACK_WRITE;
    case (o)
      OP_WR_VEL: vel_m[i] = v[15:0];
      OP_WR_CUR: cur_m[i] = v;
      OP_WR_PRV: prv_m[i] = v;
      OP_STEP: begin
        wave_step();
        r.ack = ACK_STEP;
      end
      OP_RD_CUR: begin
        r.rv = cur_m[i];
        r.ack = ACK_READ;
      end
      default: ;
    endcase
    return r;
  endfunction

  // drive one beat from the falling edge and hold until taken
  task automatic send(input logic [2:0] o, input logic [6:0] x, input logic [6:0] z,
                      input logic [31:0] v, input bit fixed, input ack_beat_t typed);
    ack_beat_t p;
    @(negedge clk);
    start <= 1'b1;
    op <= o;
    pos_x <= x;
    pos_z <= z;
    value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    p = apply_item(o, x, z, v);
    exp_fifo[exp_wr % EXP_DEPTH] = fixed ? typed : p;
    exp_wr++;
  endtask

  task automatic hold_off(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic drain();
    hold_off(1);
    while (exp_wr != exp_rd || busy !== 1'b0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TOS:  tos_m = d;
      CFG_REFL: refl_m = d[0];
      CFG_ABS:  abs_m = d[0];
      default: ;
    endcase
  endtask

  function automatic logic [6:0] hot_coord();
    case ($urandom_range(0, 7))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd2;
      3: return 7'd125;
      4: return 7'd126;
      5: return 7'd127;
      6: return 7'd63;
      default: return 7'd64;
    endcase
  endfunction

  dir_row_t dir_tab[23] = '{
    '{OP_RD_CUR, 7'd0,   7'd0,   32'h0,        1'b1, 32'h0,        ACK_READ},
    '{OP_RD_CUR, 7'd127, 7'd127, 32'hFFFFFFFF, 1'b1, 32'h0,        ACK_READ},
    '{OP_WR_CUR, 7'd64,  7'd64,  32'h7FFFFFFF, 1'b1, 32'h0,        ACK_WRITE},
    '{OP_RD_CUR, 7'd64,  7'd64,  32'h0,        1'b1, 32'h7FFFFFFF, ACK_READ},
    '{OP_WR_PRV, 7'd64,  7'd64,  32'h80000000, 1'b1, 32'h0,        ACK_WRITE},
    '{OP_WR_VEL, 7'd64,  7'd64,  32'hABCDFFFF, 1'b1, 32'h0,        ACK_WRITE},
    '{OP_WR_CUR, 7'd0,   7'd127, 32'h80000000, 1'b1, 32'h0,        ACK_WRITE},
    '{OP_RD_CUR, 7'd0,   7'd127, 32'h0,        1'b1, 32'h80000000, ACK_READ},
    '{OP_WR_VEL, 7'd0,   7'd127, 32'hFFFF0001, 1'b1, 32'h0,        ACK_WRITE},
    '{OP_WR_CUR, 7'd1,   7'd1,   32'h00010000, 1'b1, 32'h0,        ACK_WRITE},
    '{OP_WR_VEL, 7'd1,   7'd1,   32'h00005555, 1'b1, 32'h0,        ACK_WRITE},
    '{OP_WR_PRV, 7'd127, 7'd0,   32'h0000AAAA, 1'b1, 32'h0,        ACK_WRITE},
    '{OP_WR_CUR, 7'd126, 7'd1,   32'hFFFF0000, 1'b1, 32'h0,        ACK_WRITE},
    '{3'd5,      7'd3,   7'd3,   32'h12345678, 1'b1, 32'h0,        ACK_WRITE},
    '{3'd6,      7'd127, 7'd127, 32'h7FFFFFFF, 1'b1, 32'h0,        ACK_WRITE},
    '{3'd7,      7'd0,   7'd0,   32'h80000000, 1'b1, 32'h0,        ACK_WRITE},
    '{OP_STEP,   7'd0,   7'd0,   32'h0,        1'b0, 32'h0,        ACK_STEP},
    '{OP_RD_CUR, 7'd64,  7'd64,  32'h0,        1'b0, 32'h0,        ACK_READ},
    '{OP_RD_CUR, 7'd64,  7'd65,  32'h0,        1'b0, 32'h0,        ACK_READ},
    '{OP_RD_CUR, 7'd0,   7'd127, 32'h0,        1'b0, 32'h0,        ACK_READ},
    '{OP_RD_CUR, 7'd1,   7'd1,   32'h0,        1'b0, 32'h0,        ACK_READ},
    '{OP_STEP,   7'd0,   7'd0,   32'h0,        1'b0, 32'h0,        ACK_STEP},
    '{OP_RD_CUR, 7'd63,  7'd64,  32'h0,        1'b0, 32'h0,        ACK_READ}
  };

  initial begin
    int step_at;
    logic [2:0] o;
    logic [6:0] x, z;
    logic [31:0] v;
    for (int c = 0; c < CELLS; c++) begin
      vel_m[c] = '0; prv_m[c] = '0; cur_m[c] = '0; nxt_m[c] = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_tab[r])
      send(dir_tab[r].op, dir_tab[r].x, dir_tab[r].z, dir_tab[r].val, dir_tab[r].fixed,
           '{dir_tab[r].rv, dir_tab[r].ack});

    // random phases, each under its own register setting
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(CFG_TOS, 32'hFFFFFFFF); write_reg(CFG_REFL, 32'd0);
          write_reg(CFG_ABS, 32'd1);
        end
        1: begin
          write_reg(CFG_TOS, 32'd0); write_reg(CFG_REFL, 32'd1);
          write_reg(CFG_ABS, 32'd0);
        end
        2: begin
          write_reg(CFG_TOS, $urandom); write_reg(CFG_REFL, 32'd0);
          write_reg(CFG_ABS, 32'd1);
        end
        default: begin
          write_reg(CFG_TOS, TOS_RESET); write_reg(CFG_REFL, 32'd1);
          write_reg(CFG_ABS, 32'd1);
        end
      endcase
      step_at = $urandom_range(10, 18);
      for (int n = 0; n < 25; n++) begin
        if (ph < 3 && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 15));
        x = ($urandom_range(0, 3) == 0) ? 7'($urandom) : hot_coord();
        z = ($urandom_range(0, 3) == 0) ? 7'($urandom) : hot_coord();
        v = ($urandom_range(0, 1) == 0) ? $urandom :
            (($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 32'h3FFFF)) :
             -32'($urandom_range(0, 32'h3FFFF)));
        case ($urandom_range(0, 9))
          0, 1:    o = OP_WR_VEL;
          2, 3, 4: o = OP_WR_CUR;
          5:       o = OP_WR_PRV;
          6, 7, 8: o = OP_RD_CUR;
          default: o = 3'($urandom_range(5, 7));
        endcase
        if (n == step_at) o = OP_STEP;
        send(o, x, z, v, 1'b0, '0);
      end
    end

    // wind down
    hold_off(1);
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
